### rtl/haws_pkg.sv
`timescale 1ns / 1ps
package haws_pkg;
  localparam int THR_BITS = 23;   // threshold width
  localparam int Q_BITS   = 23;   // garrote quotient width, quotient < T
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_HARD    = 2'd1;
  localparam logic [1:0] MODE_SOFT    = 2'd2;
  localparam logic [1:0] MODE_GARROTE = 2'd3;
  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_THR  = 1'b1;
endpackage

### rtl/haar_wavelet_shrink_2x2.sv
`timescale 1ns / 1ps
// Channel  | handshake          | payload
// input    | in_valid/in_stall  | in_command, in_a..in_d
// result   | out_valid/out_stall| out_a..out_d
// config   | APB psel/penable   | paddr[2] selects shrink_mode or threshold
//
// One 2x2 word enters every cycle unless in_stall holds it off; the garrote
// divider resolves one quotient bit per stage for each of three details.
// Each stage holds its word while the next one is full and stalled, so a
// stall loses nothing and bubbles get squeezed out. Synchronous active-low
// reset clears the valid bits and the config registers.
module haar_wavelet_shrink_2x2
  import haws_pkg::*;
#(
  parameter int DATA_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic signed [DATA_WIDTH-1:0] in_a,
  input  logic signed [DATA_WIDTH-1:0] in_b,
  input  logic signed [DATA_WIDTH-1:0] in_c,
  input  logic signed [DATA_WIDTH-1:0] in_d,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_a,
  output logic signed [DATA_WIDTH-1:0] out_b,
  output logic signed [DATA_WIDTH-1:0] out_c,
  output logic signed [DATA_WIDTH-1:0] out_d,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  localparam int W  = DATA_WIDTH;
  localparam int DW = W + 1;                      // detail width
  localparam int RW = (DW + Q_BITS > 2 * THR_BITS) ? DW + Q_BITS : 2 * THR_BITS;
  localparam int NS = Q_BITS + 3;                 // butterfly, setup, divider, select

  typedef struct packed {
    logic                        cmd;
    logic [DW-1:0]               ap;
    logic [2:0][DW-1:0]          det;
    logic [2:0][DW-1:0]          mag;
    logic [2:0]                  gt;
    logic [2:0][RW-1:0]          rem;
    logic [2:0][Q_BITS-1:0]      q;
  } stage_t;

  // config
  logic [1:0]          mode_r;
  logic [THR_BITS-1:0] thr_r;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      thr_r  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MODE) mode_r <= pwdata[1:0];
      else                      thr_r  <= pwdata[THR_BITS-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_THR) ? {{(32-THR_BITS){1'b0}}, thr_r}
                                        : {30'd0, mode_r};

  // pipeline
  stage_t         st_r [NS];
  stage_t         st_nxt [NS];
  logic [NS-1:0]  v_r;
  logic [NS:0]    adv;
  logic           out_valid_r;
  logic signed [W-1:0] oa_r, ob_r, oc_r, od_r;

  assign adv[NS] = !out_valid_r || !out_stall;
  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = !v_r[k] || adv[k+1];
    end
  endgenerate
  assign in_stall = !adv[0];

  // butterfly
  logic signed [DW:0] s0, s1, s2, s3;
  always_comb begin
    s0 = DW'(in_a) + DW'(in_b) + DW'(in_c) + DW'(in_d);
    s1 = DW'(in_a) + DW'(in_c) - DW'(in_b) - DW'(in_d);
    s2 = DW'(in_a) + DW'(in_b) - DW'(in_c) - DW'(in_d);
    s3 = DW'(in_a) - DW'(in_b) - DW'(in_c) + DW'(in_d);
    st_nxt[0]     = '0;
    st_nxt[0].cmd = in_command;
    if (in_command == CMD_FWD) begin
      st_nxt[0].ap     = s0[DW:1];
      st_nxt[0].det[0] = s1[DW:1];
      st_nxt[0].det[1] = s2[DW:1];
      st_nxt[0].det[2] = s3[DW:1];
    end else begin
      st_nxt[0].ap     = DW'(in_a);
      st_nxt[0].det[0] = DW'(in_b);
      st_nxt[0].det[1] = DW'(in_c);
      st_nxt[0].det[2] = DW'(in_d);
    end
  end

  // magnitude, threshold compare, T*T
  logic [2*THR_BITS-1:0] tt;
  always_comb begin
    tt        = thr_r * thr_r;
    st_nxt[1] = st_r[0];
    for (int i = 0; i < 3; i++) begin
      st_nxt[1].mag[i] = st_r[0].det[i][DW-1] ? (DW)'(-st_r[0].det[i]) : st_r[0].det[i];
      st_nxt[1].gt[i]  = RW'(st_nxt[1].mag[i]) > RW'(thr_r);
      st_nxt[1].rem[i] = RW'(tt);
      st_nxt[1].q[i]   = '0;
    end
  end

  // divider: stage 2+j resolves quotient bit Q_BITS-1-j
  generate
    for (k = 0; k < Q_BITS; k++) begin : g_div
      logic [2:0][RW-1:0] rem_n;
      logic [2:0]         qb;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        haws_div_step #(.RW(RW)) u_step (
          .rem    (st_r[k+1].rem[l]),
          .dvs    (RW'(st_r[k+1].mag[l]) << (Q_BITS - 1 - k)),
          .rem_nxt(rem_n[l]),
          .qbit   (qb[l])
        );
      end
      always_comb begin
        st_nxt[k+2] = st_r[k+1];
        for (int i = 0; i < 3; i++) begin
          st_nxt[k+2].rem[i]              = rem_n[i];
          st_nxt[k+2].q[i][Q_BITS-1-k]    = qb[i];
        end
      end
    end
  endgenerate

  // shrink select
  logic [DW-1:0] soft_m [3];
  logic [DW-1:0] qx [3];
  always_comb begin
    st_nxt[NS-1] = st_r[NS-2];
    for (int i = 0; i < 3; i++) begin
      soft_m[i] = st_r[NS-2].mag[i] - DW'(thr_r);
      qx[i]     = DW'(st_r[NS-2].q[i]);
      if (mode_r == MODE_NONE)
        st_nxt[NS-1].det[i] = st_r[NS-2].det[i];
      else if (!st_r[NS-2].gt[i])
        st_nxt[NS-1].det[i] = '0;
      else begin
        case (mode_r)
          MODE_HARD: st_nxt[NS-1].det[i] = st_r[NS-2].det[i];
          MODE_SOFT: st_nxt[NS-1].det[i] = st_r[NS-2].det[i][DW-1] ? -soft_m[i] : soft_m[i];
          default:   st_nxt[NS-1].det[i] = st_r[NS-2].det[i][DW-1]
                                           ? st_r[NS-2].det[i] + qx[i]
                                           : st_r[NS-2].det[i] - qx[i];
        endcase
      end
    end
  end

  generate
    for (k = 0; k < NS; k++) begin : g_reg
      always_ff @(posedge clk) begin
        if (!rst_n) v_r[k] <= 1'b0;
        else if (adv[k]) v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
      always_ff @(posedge clk) begin
        if (adv[k]) st_r[k] <= st_nxt[k];
      end
    end
  endgenerate

  // rebuild / saturate
  function automatic logic signed [W-1:0] sat(input logic signed [DW:0] v);
    logic signed [DW:0] hi;
    logic signed [DW:0] lo;
    hi = (DW+1)'((64'sd1 <<< (W-1)) - 1);
    lo = -hi - 1;
    if (v > hi)      sat = hi[W-1:0];
    else if (v < lo) sat = lo[W-1:0];
    else             sat = v[W-1:0];
  endfunction

  stage_t fs;
  logic signed [DW+1:0] ap_x, h_x, v_x, g_x, r0, r1, r2, r3;
  logic signed [W-1:0] oa_nxt, ob_nxt, oc_nxt, od_nxt;
  always_comb begin
    fs   = st_r[NS-1];
    ap_x = (DW+2)'($signed(fs.ap));
    h_x  = (DW+2)'($signed(fs.det[0]));
    v_x  = (DW+2)'($signed(fs.det[1]));
    g_x  = (DW+2)'($signed(fs.det[2]));
    r0 = ap_x + h_x + v_x + g_x;
    r1 = ap_x - h_x + v_x - g_x;
    r2 = ap_x + h_x - v_x - g_x;
    r3 = ap_x - h_x - v_x + g_x;
    if (fs.cmd == CMD_FWD) begin
      oa_nxt = sat(ap_x[DW:0]);
      ob_nxt = sat(h_x[DW:0]);
      oc_nxt = sat(v_x[DW:0]);
      od_nxt = sat(g_x[DW:0]);
    end else begin
      oa_nxt = sat(r0[DW+1:1]);
      ob_nxt = sat(r1[DW+1:1]);
      oc_nxt = sat(r2[DW+1:1]);
      od_nxt = sat(r3[DW+1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv[NS]) out_valid_r <= v_r[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      oa_r <= oa_nxt;
      ob_r <= ob_nxt;
      oc_r <= oc_nxt;
      od_r <= od_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_a = oa_r;
  assign out_b = ob_r;
  assign out_c = oc_r;
  assign out_d = od_r;
endmodule

### rtl/haws_div_step.sv
`timescale 1ns / 1ps
// One restoring division step: subtract the shifted divisor if it fits.
module haws_div_step #(
  parameter int RW = 48
) (
  input  logic [RW-1:0] rem,
  input  logic [RW-1:0] dvs,
  output logic [RW-1:0] rem_nxt,
  output logic          qbit
);
  always_comb begin
    qbit    = (rem >= dvs);
    rem_nxt = qbit ? (rem - dvs) : rem;
  end
endmodule
